// ===== rtl/vpc_pkg.sv =====
// vpc_pkg: shared types, constants and helpers of the vector polar/cartesian converter
// used by vpc_prep, vpc_cordic_stage, vpc_finish and the top level, no dependencies

package vpc_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 20;
  localparam int ANG_FRAC         = 30;
  localparam int EXTRA_BITS       = 24;
  localparam int ROOT_STAGES      = 32;
  localparam int CW               = 58;   // cordic x/y datapath
  localparam int ZW               = 34;   // angle accumulator
  localparam int RW               = 35;   // square root remainder

  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [32:0] PI_Q30      = 33'd3373259426;
  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [29:0] KINV_Q30    = 30'd652032874;
  // floor(2^62 / 2pi_q30), fits in 30 bits
  localparam logic [63:0] RECIP_62    = 64'h4000_0000_0000_0000 / {31'd0, TWO_PI_Q30};

  localparam logic signed [39:0] SAT_HI = 40'sd2147483647;
  localparam logic signed [39:0] SAT_LO = -40'sd2147483648;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [1:0] {
    KIND_CART  = 2'd0,
    KIND_POLAR = 2'd1,
    KIND_ADD   = 2'd2,
    KIND_SUB   = 2'd3
  } vpc_kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_UNDEF = 2'd2
  } vpc_status_e;

  // one item in flight through the cordic / square root chain
  typedef struct packed {
    logic                 rot;   // polar item, rotation mode
    logic                 sat;
    logic                 neg;
    logic                 zx;
    logic                 zy;
    logic signed [31:0]   px;
    logic signed [31:0]   py;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] cz;
    logic [63:0]          sq;    // radicand, shifted out two bits a stage
    logic [31:0]          root;
    logic [RW-1:0]        rem;
  } vpc_cord_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > SAT_HI) begin
      sat32 = 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic ovf32(input logic signed [39:0] v);
    ovf32 = (v > SAT_HI) || (v < SAT_LO);
  endfunction

endpackage

// ===== rtl/vpc_in_if.sv =====
// vpc_in_if: input channel of the converter, valid/ready plus one input item
// no dependencies

interface vpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] first_x;
  logic [31:0] first_y;
  logic [31:0] second_x;
  logic [31:0] second_y;

  modport source (output valid, kind, first_x, first_y, second_x, second_y, input ready);
  modport sink   (input valid, kind, first_x, first_y, second_x, second_y, output ready);
endinterface

// ===== rtl/vpc_out_if.sv =====
// vpc_out_if: result channel of the converter, valid/ready plus one result item
// no dependencies

interface vpc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [32:0] out_magnitude;
  logic [31:0] out_angle;
  logic [1:0]  status;

  modport source (output valid, out_x, out_y, out_magnitude, out_angle, status, input ready);
  modport sink   (input valid, out_x, out_y, out_magnitude, out_angle, status, output ready);
endinterface

// ===== rtl/vpc_prep.sv =====
// vpc_prep: five-stage front end, vector sums, squares, angle reduction, cordic seeds
// depends on vpc_pkg and vpc_in_if

module vpc_prep import vpc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  vpc_in_if.sink        in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output vpc_cord_t     out_data_o
);

  localparam int SH  = ANG_FRAC - FRAC_BITS;
  localparam int RS  = 62 - SH;
  localparam int QW  = SH + 2;
  localparam int RMW = SH + 36;

  localparam logic signed [30:0]    RECIP_S = {1'b0, RECIP_62[29:0]};
  localparam logic signed [30:0]    KINV_S  = {1'b0, KINV_Q30};
  localparam logic signed [33:0]    TWO_S   = {1'b0, TWO_PI_Q30};
  localparam logic signed [RMW-1:0] TWO_W   = RMW'(TWO_S);
  localparam logic signed [ZW-1:0]  HALF_Z  = ZW'(HALF_PI_Q30);
  localparam logic signed [ZW-1:0]  PI_Z    = ZW'(PI_Q30);
  localparam logic signed [ZW-1:0]  TWO_Z   = ZW'(TWO_PI_Q30);
  localparam logic signed [ZW-1:0]  THR_Z   = TWO_Z - HALF_Z;

  logic [4:0] v_q;
  logic [4:0] adv;

  always_comb begin
    adv[4] = !v_q[4] || out_ready_i;
    for (int k = 3; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_i.ready  = adv[0];
  assign out_valid_o = v_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < 5; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 1: sums with saturation, reduction and gain multiplies
  vpc_kind_e          kind_in;
  logic signed [31:0] x1, y1, x2, y2;
  logic signed [32:0] sum_x, sum_y;
  logic               is_sum;

  vpc_kind_e          kind1_q;
  logic signed [31:0] vx1_q, vy1_q;
  logic               sat1_q;
  logic signed [62:0] pa1_q, pm1_q;

  always_comb begin
    kind_in = vpc_kind_e'(in_i.kind);
    x1 = in_i.first_x;
    y1 = in_i.first_y;
    x2 = in_i.second_x;
    y2 = in_i.second_y;
    is_sum = (kind_in == KIND_ADD) || (kind_in == KIND_SUB);
    if (kind_in == KIND_ADD) begin
      sum_x = 33'(x1) + 33'(x2);
      sum_y = 33'(y1) + 33'(y2);
    end else begin
      sum_x = 33'(x1) - 33'(x2);
      sum_y = 33'(y1) - 33'(y2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      kind1_q <= kind_in;
      vx1_q   <= is_sum ? sat32(40'(sum_x)) : x1;
      vy1_q   <= is_sum ? sat32(40'(sum_y)) : y1;
      sat1_q  <= is_sum && (ovf32(40'(sum_x)) || ovf32(40'(sum_y)));
      pa1_q   <= y1 * RECIP_S;
      pm1_q   <= x1 * KINV_S;
    end
  end

  // stage 2: magnitudes squared, quotient estimate times 2pi
  logic [31:0]          ax, ay;
  logic signed [QW-1:0] q_est;

  vpc_kind_e            kind2_q;
  logic signed [31:0]   vx2_q, vy2_q;
  logic                 sat2_q, zx2_q, zy2_q;
  logic [31:0]          ax2_q, ay2_q;
  logic [63:0]          sqx2_q, sqy2_q;
  logic signed [RMW-1:0] qt2_q;
  logic signed [CW-1:0] x02_q;

  always_comb begin
    ax    = vx1_q[31] ? (~vx1_q + 32'd1) : vx1_q;
    ay    = vy1_q[31] ? (~vy1_q + 32'd1) : vy1_q;
    q_est = QW'(pa1_q >>> RS);
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      kind2_q <= kind1_q;
      vx2_q   <= vx1_q;
      vy2_q   <= vy1_q;
      sat2_q  <= sat1_q;
      zx2_q   <= (vx1_q == 32'sd0);
      zy2_q   <= (vy1_q == 32'sd0);
      ax2_q   <= ax;
      ay2_q   <= ay;
      sqx2_q  <= 64'(ax) * 64'(ax);
      sqy2_q  <= 64'(ay) * 64'(ay);
      qt2_q   <= RMW'(q_est) * TWO_W;
      x02_q   <= CW'(pm1_q >>> (ANG_FRAC - EXTRA_BITS));
    end
  end

  // stage 3: radicand and first remainder of the angle reduction
  vpc_kind_e             kind3_q;
  logic signed [31:0]    vx3_q, vy3_q;
  logic                  sat3_q, zx3_q, zy3_q;
  logic [31:0]           ax3_q, ay3_q;
  logic [63:0]           s3_q;
  logic signed [RMW-1:0] r03_q;
  logic signed [CW-1:0]  x03_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      kind3_q <= kind2_q;
      vx3_q   <= vx2_q;
      vy3_q   <= vy2_q;
      sat3_q  <= sat2_q;
      zx3_q   <= zx2_q;
      zy3_q   <= zy2_q;
      ax3_q   <= ax2_q;
      ay3_q   <= ay2_q;
      s3_q    <= sqx2_q + sqy2_q;
      r03_q   <= (RMW'(vy2_q) <<< SH) - qt2_q;
      x03_q   <= x02_q;
    end
  end

  // stage 4: correct the quotient by one either way, angle now in 0..2pi
  vpc_kind_e            kind4_q;
  logic signed [31:0]   vx4_q, vy4_q;
  logic                 sat4_q, zx4_q, zy4_q;
  logic [31:0]          ax4_q, ay4_q;
  logic [63:0]          s4_q;
  logic signed [ZW-1:0] r14_q;
  logic signed [CW-1:0] x04_q;
  logic signed [ZW-1:0] r1;

  always_comb begin
    if (r03_q < 0) begin
      r1 = ZW'(r03_q + TWO_W);
    end else if (r03_q >= TWO_W) begin
      r1 = ZW'(r03_q - TWO_W);
    end else begin
      r1 = ZW'(r03_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      kind4_q <= kind3_q;
      vx4_q   <= vx3_q;
      vy4_q   <= vy3_q;
      sat4_q  <= sat3_q;
      zx4_q   <= zx3_q;
      zy4_q   <= zy3_q;
      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;
      s4_q    <= s3_q;
      r14_q   <= r1;
      x04_q   <= x03_q;
    end
  end

  // stage 5: fold into -pi/2..pi/2 and seed the chain
  logic signed [ZW-1:0] z0;
  logic                 neg0;
  logic                 rot;
  vpc_cord_t            seed;
  vpc_cord_t            out_q;

  always_comb begin
    if (r14_q <= HALF_Z) begin
      z0 = r14_q;
      neg0 = 1'b0;
    end else if (r14_q < THR_Z) begin
      z0 = r14_q - PI_Z;
      neg0 = 1'b1;
    end else begin
      z0 = r14_q - TWO_Z;
      neg0 = 1'b0;
    end
    rot       = (kind4_q == KIND_POLAR);
    seed.rot  = rot;
    seed.sat  = sat4_q;
    seed.neg  = rot && neg0;
    seed.zx   = zx4_q;
    seed.zy   = zy4_q;
    seed.px   = vx4_q;
    seed.py   = vy4_q;
    seed.cx   = rot ? x04_q : $signed({2'b00, ax4_q, {EXTRA_BITS{1'b0}}});
    seed.cy   = rot ? '0 : $signed({2'b00, ay4_q, {EXTRA_BITS{1'b0}}});
    seed.cz   = rot ? z0 : '0;
    seed.sq   = s4_q;
    seed.root = '0;
    seed.rem  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) out_q <= seed;
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/vpc_cordic_stage.sv =====
// vpc_cordic_stage: one cordic iteration (only below CORDIC_STEPS) and one square root digit, registered
// depends on vpc_pkg

module vpc_cordic_stage import vpc_pkg::*; #(
  parameter int STAGE        = 0,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  vpc_cord_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output vpc_cord_t out_data_o
);

  localparam logic signed [ZW-1:0] ATAN_Z = ZW'($signed({1'b0, ATAN_Q30[STAGE]}));

  logic      v_q;
  logic      adv;
  vpc_cord_t d_q;
  vpc_cord_t nx;

  logic signed [CW-1:0] x, y, xs, ys;
  logic signed [ZW-1:0] z;
  logic [RW-1:0]        rem_sh, trial;

  assign adv = !v_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    nx = in_data_i;
    x  = in_data_i.cx;
    y  = in_data_i.cy;
    z  = in_data_i.cz;
    xs = x >>> STAGE;
    ys = y >>> STAGE;
    if (STAGE < CORDIC_STEPS) begin
      if (in_data_i.rot) begin
        if (z >= 0) begin
          nx.cx = x - ys;
          nx.cy = y + xs;
          nx.cz = z - ATAN_Z;
        end else begin
          nx.cx = x + ys;
          nx.cy = y - xs;
          nx.cz = z + ATAN_Z;
        end
      end else begin
        if (y > 0) begin
          nx.cx = x + ys;
          nx.cy = y - xs;
          nx.cz = z + ATAN_Z;
        end else begin
          nx.cx = x - ys;
          nx.cy = y + xs;
          nx.cz = z - ATAN_Z;
        end
      end
    end
    // square root digit
    rem_sh = {in_data_i.rem[RW-3:0], in_data_i.sq[63:62]};
    trial  = {1'b0, in_data_i.root, 2'b01};
    nx.sq  = {in_data_i.sq[61:0], 2'b00};
    if (rem_sh >= trial) begin
      nx.rem  = rem_sh - trial;
      nx.root = {in_data_i.root[30:0], 1'b1};
    end else begin
      nx.rem  = rem_sh;
      nx.root = {in_data_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) d_q <= nx;
  end

  assign out_valid_o = v_q;
  assign out_data_o  = d_q;

endmodule

// ===== rtl/vpc_finish.sv =====
// vpc_finish: rounding, special cases, saturation and the result register
// depends on vpc_pkg and vpc_out_if

module vpc_finish import vpc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  vpc_cord_t in_data_i,
  vpc_out_if.source out_o
);

  localparam int SH = ANG_FRAC - FRAC_BITS;
  localparam logic signed [ZW-1:0] HALF_Z  = ZW'(HALF_PI_Q30);
  localparam logic signed [ZW-1:0] ARND    = ZW'(1) <<< (SH - 1);
  localparam logic signed [ZW-1:0] HALF_RZ = (HALF_Z + ARND) >>> SH;
  localparam logic signed [31:0]   HALF_OUT = 32'(HALF_RZ);
  localparam logic signed [CW-1:0] XRND    = CW'(1) <<< (EXTRA_BITS - 1);

  logic v_q;
  logic adv;

  logic signed [CW-1:0] rx, ry;
  logic signed [ZW-1:0] zc, za;
  logic signed [31:0]   sx, sy, ang;
  logic                 psat;
  logic [32:0]          mag;
  vpc_status_e          st;

  logic signed [31:0] x_q, y_q, ang_q;
  logic [32:0]        mag_q;
  vpc_status_e        st_q;

  assign adv = !v_q || out_o.ready;
  assign in_ready_o = adv;

  always_comb begin
    rx = (in_data_i.cx + XRND) >>> EXTRA_BITS;
    ry = (in_data_i.cy + XRND) >>> EXTRA_BITS;
    if (in_data_i.neg) begin
      rx = -rx;
      ry = -ry;
    end
    sx   = sat32(40'(rx));
    sy   = sat32(40'(ry));
    psat = ovf32(40'(rx)) || ovf32(40'(ry));

    if (in_data_i.cz < 0) begin
      zc = '0;
    end else if (in_data_i.cz > HALF_Z) begin
      zc = HALF_Z;
    end else begin
      zc = in_data_i.cz;
    end
    za = (zc + ARND) >>> SH;

    mag = {1'b0, in_data_i.root} + 33'(in_data_i.rem > {3'b000, in_data_i.root});

    if (in_data_i.zx && in_data_i.zy) begin
      ang = '0;
    end else if (in_data_i.zx) begin
      ang = HALF_OUT;
    end else if (in_data_i.zy) begin
      ang = '0;
    end else begin
      ang = 32'(za);
    end

    if (in_data_i.rot) begin
      st = psat ? ST_SAT : ST_OK;
    end else if (in_data_i.zx && in_data_i.zy) begin
      st = ST_UNDEF;
    end else begin
      st = in_data_i.sat ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q   <= in_data_i.rot ? sx : in_data_i.px;
      y_q   <= in_data_i.rot ? sy : in_data_i.py;
      mag_q <= in_data_i.rot ? {in_data_i.px[31], in_data_i.px} : mag;
      ang_q <= in_data_i.rot ? in_data_i.py : ang;
      st_q  <= st;
    end
  end

  assign out_o.valid         = v_q;
  assign out_o.out_x         = x_q;
  assign out_o.out_y         = y_q;
  assign out_o.out_magnitude = mag_q;
  assign out_o.out_angle     = ang_q;
  assign out_o.status        = st_q;

`ifndef SYNTHESIS
  a_undef_zero_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q && st_q == ST_UNDEF) |-> (mag_q == '0 && ang_q == '0))
    else $error("zero vector result with nonzero magnitude or angle");

  a_undef_zero_xy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q && st_q == ST_UNDEF) |-> (x_q == '0 && y_q == '0))
    else $error("undefined angle flagged on a nonzero vector");

  a_ref_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && adv && !in_data_i.rot) |=> (ang_q >= 0 && ang_q <= HALF_OUT))
    else $error("reference angle outside 0..pi/2");
`endif

endmodule

// ===== rtl/vector_polar_cartesian_convert.sv =====
// vector_polar_cartesian_convert: top level of the vector polar/cartesian converter
// depends on vpc_pkg, vpc_in_if, vpc_out_if, vpc_prep, vpc_cordic_stage, vpc_finish
//
// usage
// - in_i carries one item per valid/ready handshake: kind, first_x/first_y and, for
//   add or subtract, second_x/second_y, all Q16.16 (polar: magnitude and angle)
// - out_o returns exactly one result item per input item, in order: x, y, magnitude,
//   reference angle or polar angle, and a status code (ok, saturated, zero vector)
// - an item passes 5 front-end stages (sums, squares, angle reduction), 32 stages
//   of square root digit (cordic too in the first CORDIC_STEPS), 1 output stage
// - throughput is one item per cycle while out_o accepts results; every stage holds its own valid bit
// - when out_o stalls, items pile up behind the output register and fill bubbles;
//   in_i.ready drops only once every stage is full, nothing is lost or repeated
// - reset clears all valid bits; the data registers are not reset

module vector_polar_cartesian_convert import vpc_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vpc_in_if.sink    in_i,
  vpc_out_if.source out_o
);

  // chain links: index 0 is the front-end output, ROOT_STAGES feeds the output stage
  vpc_cord_t              cd [ROOT_STAGES+1];
  logic [ROOT_STAGES:0]   cv;
  logic [ROOT_STAGES:0]   cr;

  // front end: sums and saturation, squares, angle reduction mod 2pi, seeds
  vpc_prep #(
    .FRAC_BITS (FRAC_BITS)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_valid_o (cv[0]),
    .out_ready_i (cr[0]),
    .out_data_o  (cd[0])
  );

  // cordic iterations beyond CORDIC_STEPS only carry the square root along
  for (genvar i = 0; i < ROOT_STAGES; i++) begin : g_stage
    vpc_cordic_stage #(
      .STAGE        (i),
      .CORDIC_STEPS (CORDIC_STEPS)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cv[i]),
      .in_ready_o  (cr[i]),
      .in_data_i   (cd[i]),
      .out_valid_o (cv[i+1]),
      .out_ready_i (cr[i+1]),
      .out_data_o  (cd[i+1])
    );
  end

  // rounding, special angles, saturation, result register
  vpc_finish #(
    .FRAC_BITS (FRAC_BITS)
  ) u_finish (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cv[ROOT_STAGES]),
    .in_ready_o (cr[ROOT_STAGES]),
    .in_data_i  (cd[ROOT_STAGES]),
    .out_o      (out_o)
  );

endmodule
